// ===== rtl/crm_pkg.sv =====
`timescale 1ns / 1ps

package crm_pkg;

  localparam int NUM_REGS = 16;
  localparam int REG_IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int LAST_REG_W = 4;

  localparam int ID_W = 29;
  localparam int LEN_W = 4;
  localparam int IDX_W = 8;
  localparam int WORD_W = 32;
  localparam int HOLD_W = 8;
  localparam int AGE_W = 16;
  localparam int PERIOD_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 29;

  localparam logic [IDX_W:0] IDX_LIMIT = (IDX_W + 1)'(NUM_REGS);
  localparam logic [LEN_W-1:0] FRAME_LEN_FULL = LEN_W'(8);
  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  localparam logic [ID_W-1:0] ACCEPT_ID_RST = ID_W'(3);
  localparam logic [HOLD_W-1:0] LED_HOLD_RST = HOLD_W'(50);
  localparam logic [PERIOD_W-1:0] TELEM_PERIOD_RST = PERIOD_W'(10000);

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_HOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TELEM_PERIOD = 2'd2;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_FRAME = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ID_W-1:0]   frame_id;
    logic [LEN_W-1:0]  frame_len;
    logic [IDX_W-1:0]  reg_index;
    logic [WORD_W-1:0] payload_word;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]     accept_id;
    logic [HOLD_W-1:0]   led_hold;
    logic [PERIOD_W-1:0] telem_period;
  } cfg_t;

  typedef struct packed {
    logic                  led_lit;
    logic                  telem_due;
    logic [AGE_W-1:0]      data_age;
    logic [LAST_REG_W-1:0] last_reg;
    logic                  frame_accepted;
    logic [WORD_W-1:0]     read_data;
  } rsp_t;

endpackage

// ===== rtl/crm_cfg_regs.sv =====
`timescale 1ns / 1ps

module crm_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [crm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output crm_pkg::cfg_t                  cfg
);
  import crm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accept_id <= ACCEPT_ID_RST;
      cfg.led_hold <= LED_HOLD_RST;
      cfg.telem_period <= TELEM_PERIOD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ACCEPT_ID:    cfg.accept_id <= cfg_wdata[ID_W-1:0];
        CFG_LED_HOLD:     cfg.led_hold <= cfg_wdata[HOLD_W-1:0];
        CFG_TELEM_PERIOD: cfg.telem_period <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/crm_core.sv =====
`timescale 1ns / 1ps

module crm_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  crm_pkg::req_t req,
  input  crm_pkg::cfg_t cfg,
  output crm_pkg::rsp_t rsp
);
  import crm_pkg::*;

  logic [WORD_W-1:0]     mirror [NUM_REGS];
  logic [AGE_W-1:0]      age_count, age_count_next;
  logic [HOLD_W-1:0]     led_count, led_count_next;
  logic                  led_level, led_level_next;
  logic [PERIOD_W-1:0]   telem_ticks, telem_ticks_next;
  logic [LAST_REG_W-1:0] recent_reg, recent_reg_next;

  logic                 in_range;
  logic                 store;
  logic                 due;
  logic [REG_IDX_W-1:0] widx;
  req_type_t            rtype;

  assign rtype = req_type_t'(req.req_type);
  assign in_range = ({1'b0, req.reg_index} < IDX_LIMIT);
  assign widx = req.reg_index[REG_IDX_W-1:0];

  always_comb begin
    age_count_next = age_count;
    led_count_next = led_count;
    led_level_next = led_level;
    telem_ticks_next = telem_ticks;
    recent_reg_next = recent_reg;
    store = 1'b0;
    due = 1'b0;
    case (rtype)
      REQ_TICK: begin
        if (age_count != AGE_MAX) age_count_next = age_count + AGE_W'(1);
        if (telem_ticks < cfg.telem_period) begin
          telem_ticks_next = telem_ticks + PERIOD_W'(1);
        end else begin
          due = 1'b1;
          telem_ticks_next = '0;
        end
        if (led_count == '0) begin
          led_level_next = 1'b0;
        end else begin
          led_level_next = 1'b1;
          led_count_next = led_count - HOLD_W'(1);
        end
      end
      REQ_FRAME: begin
        led_count_next = cfg.led_hold;
        if (req.frame_id == cfg.accept_id && req.frame_len == FRAME_LEN_FULL && in_range) begin
          store = 1'b1;
          recent_reg_next = req.reg_index[LAST_REG_W-1:0];
          age_count_next = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp.led_lit = led_level_next;
    rsp.telem_due = due;
    rsp.data_age = age_count_next;
    rsp.last_reg = recent_reg_next;
    rsp.frame_accepted = store;
    rsp.read_data = (rtype == REQ_READ && in_range) ? mirror[widx] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age_count <= '0;
      led_count <= '0;
      led_level <= 1'b0;
      telem_ticks <= '0;
      recent_reg <= '0;
    end else if (go) begin
      age_count <= age_count_next;
      led_count <= led_count_next;
      led_level <= led_level_next;
      telem_ticks <= telem_ticks_next;
      recent_reg <= recent_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) mirror[i] <= '0;
    end else if (go && store) begin
      mirror[widx] <= req.payload_word;
    end
  end

endmodule

// ===== rtl/can_register_mirror_with_ages.sv =====
`timescale 1ns / 1ps

// CAN register mirror with data age, LED hold and telemetry pacing.
// Input channel (in_valid/in_ready) carries one request per transaction:
// a millisecond tick, a received CAN frame or a register read, chosen by
// req_type. Output channel (out_valid/out_ready) returns exactly one result
// per request, in order, showing the state after that request.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata):
// index 0 accept_id, 1 led_hold, 2 telem_period; write only while idle.
// Each accepted request passes the input register, then its state update
// is written into the result register, from which its result is shown.
// Throughput: one request per cycle, sustained, as long as out_ready is high.
// When the receiver stalls, the result register holds and the input
// register fills; in_ready falls only when both are occupied.
// Reset (rst, synchronous, active high) clears the mirror words, all
// counters, the LED level and the remembered index, empties both stages
// and loads the register defaults (accept_id 3, led_hold 50,
// telem_period 10000).
module can_register_mirror_with_ages (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      req_type,
  input  logic [crm_pkg::ID_W-1:0]        frame_id,
  input  logic [crm_pkg::LEN_W-1:0]       frame_len,
  input  logic [crm_pkg::IDX_W-1:0]       reg_index,
  input  logic [crm_pkg::WORD_W-1:0]      payload_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            led_lit,
  output logic                            telem_due,
  output logic [crm_pkg::AGE_W-1:0]       data_age,
  output logic [crm_pkg::LAST_REG_W-1:0]  last_reg,
  output logic                            frame_accepted,
  output logic [crm_pkg::WORD_W-1:0]      read_data,
  input  logic                            cfg_wr_en,
  input  logic [crm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import crm_pkg::*;

  cfg_t cfg;
  req_t s1_req;
  logic s1_valid;
  logic s1_go;
  rsp_t rsp;
  rsp_t out_rsp;

  assign s1_go = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  crm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  crm_core u_core (
    .clk (clk),
    .rst (rst),
    .go  (s1_go),
    .req (s1_req),
    .cfg (cfg),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // capture the transaction whenever the input stage can take it
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req.req_type <= req_type;
      s1_req.frame_id <= frame_id;
      s1_req.frame_len <= frame_len;
      s1_req.reg_index <= reg_index;
      s1_req.payload_word <= payload_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) out_rsp <= rsp;
  end

  assign led_lit = out_rsp.led_lit;
  assign telem_due = out_rsp.telem_due;
  assign data_age = out_rsp.data_age;
  assign last_reg = out_rsp.last_reg;
  assign frame_accepted = out_rsp.frame_accepted;
  assign read_data = out_rsp.read_data;

endmodule
